// ----- hw/rtl/pctf_pkg.sv -----
// pctf_pkg: shared types and constants for the two-form pid controller
// register indexes, command codes, sequencer states, controller/datapath structs
// no dependencies
package pctf_pkg;

  localparam int REG_INDEX_W = 3;

  localparam logic [REG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SETPOINT    = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_INTEG_LIMIT = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_LOOP_FORM   = 3'd5;

  localparam logic CMD_UPDATE       = 1'b0;
  localparam logic CMD_CLEAR        = 1'b1;
  localparam logic FORM_INCREMENTAL = 1'b1;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    OP_ERR_DT,
    OP_PROP,
    OP_INTEG,
    OP_DERIV
  } mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MSTART,
    S_MWAIT,
    S_INTEG,
    S_COMMIT,
    S_CLEAR,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic    load_item;
    logic    div_start;
    logic    mul_start;
    mul_op_t op;
    logic    edt_en;
    logic    integ_en;
    logic    acc_en;
    logic    commit_en;
    logic    clear_en;
    logic    hold_en;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic dt_pos;
    logic mul_done;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/pctf_mul.sv -----
// pctf_mul: shift-add signed multiplier, one multiplier bit per cycle
// optional arithmetic right shift by FRAC_BITS, result saturated to signed 64 bits
// depends on pctf_pkg
module pctf_mul #(
  parameter int BW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          shift_en,
  input  logic [63:0]   a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [63:0]   result
);

  localparam int AW = 64;
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);
  localparam logic [PW-1:0] FMASK = (PW'(1) << FRAC_BITS) - PW'(1);

  logic [AW-1:0] mcand;
  logic [PW-1:0] prod;
  logic [CW-1:0] cnt;
  logic          run;
  logic          fin;
  logic          neg;
  logic          shf;

  logic [AW-1:0] a_mag;
  logic [BW-1:0] b_mag;
  logic [AW:0]   step_sum;
  logic [PW-1:0] prod_step;
  logic [PW-1:0] q;
  logic          rem;
  logic [PW-1:0] qq;
  logic [AW-1:0] res;

  assign a_mag     = a[AW-1] ? (~a + AW'(1)) : a;
  assign b_mag     = b[BW-1] ? (~b + BW'(1)) : b;
  assign step_sum  = {1'b0, prod[PW-1:BW]} + {1'b0, (prod[0] ? mcand : AW'(0))};
  assign prod_step = {step_sum, prod[BW-1:1]};

  always_comb begin
    q   = shf ? (prod >> FRAC_BITS) : prod;
    rem = shf && (|(prod & FMASK));
    qq  = q + PW'(rem);
    if (neg) begin
      res = (|qq[PW-1:AW-1]) ? pctf_pkg::S64_MIN : (~qq[AW-1:0] + AW'(1));
    end else begin
      res = (|q[PW-1:AW-1]) ? pctf_pkg::S64_MAX : q[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        mcand <= a_mag;
        prod  <= {AW'(0), b_mag};
        neg   <= a[AW-1] ^ b[BW-1];
        shf   <= shift_en;
      end else if (run) begin
        prod <= prod_step;
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(BW - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        result <= res;
      end
    end
  end

endmodule

// ----- hw/rtl/pctf_div.sv -----
// pctf_div: restoring divider, signed dividend by positive 32-bit divisor
// one quotient bit per cycle, truncates toward zero
// depends on nothing
module pctf_div #(
  parameter int NW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo;
  logic [30:0]   rem;
  logic [31:0]   dsr;
  logic [CW-1:0] cnt;
  logic          neg;

  logic [31:0] trial;
  logic        ge;
  logic [31:0] diff;

  assign trial    = {rem, quo[NW-1]};
  assign ge       = trial >= dsr;
  assign diff     = trial - dsr;
  assign quotient = neg ? (~quo + NW'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        neg  <= dividend[NW-1];
        quo  <= dividend[NW-1] ? (~dividend + NW'(1)) : dividend;
      end else if (busy) begin
        rem <= ge ? diff[30:0] : trial[30:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/pctf_dp.sv -----
// pctf_dp: datapath with config registers, loop state, working registers and output register
// instantiates pctf_mul and pctf_div; driven by pctf_ctrl through pctf_pkg structs
// depends on pctf_pkg, pctf_mul, pctf_div
module pctf_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pctf_pkg::dp_cmd_t                  cmd,
  output pctf_pkg::dp_status_t               status,
  input  logic                               wr_en,
  input  logic [pctf_pkg::REG_INDEX_W-1:0]   wr_index,
  input  logic [DATA_WIDTH-1:0]              wr_data,
  input  logic                               in_cmd,
  input  logic [DATA_WIDTH-1:0]              in_measurement,
  input  logic [31:0]                        in_timestamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_WIDTH-1:0]              out_drive,
  output logic                               out_updated
);

  localparam int DW = DATA_WIDTH;
  localparam int BW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int NW = DATA_WIDTH + 2;

  logic [DW-1:0] kp;
  logic [DW-1:0] ki;
  logic [DW-1:0] kd;
  logic [DW-1:0] sp;
  logic [DW-2:0] lim;
  logic          form;

  logic [DW:0]   isum;
  logic [DW:0]   perr;
  logic [DW-1:0] held;
  logic [31:0]   ptime;

  logic          item_clear;
  logic [31:0]   now;
  logic [31:0]   dt;
  logic [DW:0]   err;
  logic [DW+1:0] derr;
  logic [63:0]   edt;
  logic [DW:0]   s;
  logic [63:0]   acc;

  logic [DW:0]   err_next;
  logic [DW+1:0] derr_next;
  logic [64:0]   isum_sum;
  logic [64:0]   lim_pos;
  logic [64:0]   lim_neg;
  logic [DW:0]   s_next;
  logic [63:0]   mul_a;
  logic [BW-1:0] mul_b;
  logic [63:0]   term;
  logic          mul_done;
  logic          div_busy;
  logic [NW-1:0] der;
  logic [63:0]   acc_base;
  logic [64:0]   acc_sum;
  logic [63:0]   acc_next;
  logic [DW-1:0] drive_next;
  logic          out_free;

  assign err_next  = {sp[DW-1], sp} - {in_measurement[DW-1], in_measurement};
  assign derr_next = {err_next[DW], err_next} - {perr[DW], perr};

  // integral update with symmetric clamp
  always_comb begin
    isum_sum = {{(64 - DW){isum[DW]}}, isum} + {edt[63], edt};
    lim_pos  = 65'(lim);
    lim_neg  = ~lim_pos + 65'(1);
    if ($signed(isum_sum) > $signed(lim_pos)) begin
      s_next = lim_pos[DW:0];
    end else if ($signed(isum_sum) < $signed(lim_neg)) begin
      s_next = lim_neg[DW:0];
    end else begin
      s_next = isum_sum[DW:0];
    end
  end

  // multiplier operand selection
  always_comb begin
    case (cmd.op)
      pctf_pkg::OP_ERR_DT: begin
        mul_a = {{(63 - DW){err[DW]}}, err};
        mul_b = BW'(dt);
      end
      pctf_pkg::OP_PROP: begin
        mul_a = (form == pctf_pkg::FORM_INCREMENTAL) ? {{(62 - DW){derr[DW+1]}}, derr}
                                                     : {{(63 - DW){err[DW]}}, err};
        mul_b = BW'($signed(kp));
      end
      pctf_pkg::OP_INTEG: begin
        mul_a = (form == pctf_pkg::FORM_INCREMENTAL) ? edt : {{(63 - DW){s[DW]}}, s};
        mul_b = BW'($signed(ki));
      end
      default: begin
        mul_a = {{(64 - NW){der[NW-1]}}, der};
        mul_b = BW'($signed(kd));
      end
    endcase
  end

  pctf_mul #(
    .BW        (BW),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul_start),
    .shift_en (cmd.op != pctf_pkg::OP_ERR_DT),
    .a        (mul_a),
    .b        (mul_b),
    .done     (mul_done),
    .result   (term)
  );

  pctf_div #(
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (derr),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (der)
  );

  // saturating accumulate
  always_comb begin
    if (cmd.op == pctf_pkg::OP_PROP) begin
      acc_base = (form == pctf_pkg::FORM_INCREMENTAL) ? 64'($signed(held)) : 64'(0);
    end else begin
      acc_base = acc;
    end
    acc_sum = {acc_base[63], acc_base} + {term[63], term};
    if (acc_sum[64] != acc_sum[63]) begin
      acc_next = acc_sum[64] ? pctf_pkg::S64_MIN : pctf_pkg::S64_MAX;
    end else begin
      acc_next = acc_sum[63:0];
    end
  end

  // drive saturation to data width
  always_comb begin
    if ((&acc[63:DW-1]) || !(|acc[63:DW-1])) begin
      drive_next = acc[DW-1:0];
    end else if (acc[63]) begin
      drive_next = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      drive_next = {1'b0, {(DW - 1){1'b1}}};
    end
  end

  assign out_free = !out_valid || out_ready;

  assign status.is_clear = item_clear;
  assign status.dt_pos   = !dt[31] && (|dt);
  assign status.mul_done = mul_done;
  assign status.div_busy = div_busy;
  assign status.out_free = out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      kd   <= '0;
      sp   <= '0;
      lim  <= '1;
      form <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        pctf_pkg::REG_PROP_GAIN:   kp   <= wr_data;
        pctf_pkg::REG_INTEG_GAIN:  ki   <= wr_data;
        pctf_pkg::REG_DERIV_GAIN:  kd   <= wr_data;
        pctf_pkg::REG_SETPOINT:    sp   <= wr_data;
        pctf_pkg::REG_INTEG_LIMIT: lim  <= wr_data[DW-2:0];
        pctf_pkg::REG_LOOP_FORM:   form <= wr_data[0];
        default: ;
      endcase
    end
  end

  // loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      isum      <= '0;
      perr      <= '0;
      held      <= '0;
      ptime     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit_en) begin
        held  <= drive_next;
        perr  <= err;
        ptime <= now;
        if (form != pctf_pkg::FORM_INCREMENTAL) begin
          isum <= s;
        end
      end else if (cmd.clear_en) begin
        isum  <= '0;
        perr  <= '0;
        held  <= '0;
        ptime <= now;
      end
      if (cmd.commit_en || cmd.clear_en || cmd.hold_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_clear <= (in_cmd == pctf_pkg::CMD_CLEAR);
      now        <= in_timestamp;
      dt         <= in_timestamp - ptime;
      err        <= err_next;
      derr       <= derr_next;
    end
    if (cmd.edt_en) begin
      edt <= term;
    end
    if (cmd.integ_en) begin
      s <= s_next;
    end
    if (cmd.acc_en) begin
      acc <= acc_next;
    end
    if (cmd.commit_en) begin
      out_drive   <= drive_next;
      out_updated <= 1'b1;
    end else if (cmd.clear_en) begin
      out_drive   <= '0;
      out_updated <= 1'b1;
    end else if (cmd.hold_en) begin
      out_drive   <= held;
      out_updated <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/pctf_ctrl.sv -----
// pctf_ctrl: sequencer for the pid datapath
// issues load, multiply, divide, accumulate, commit, clear and hold commands
// depends on pctf_pkg
module pctf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pctf_pkg::dp_status_t status,
  output pctf_pkg::dp_cmd_t    cmd
);

  pctf_pkg::state_t  state;
  pctf_pkg::state_t  state_next;
  pctf_pkg::mul_op_t op;
  pctf_pkg::mul_op_t op_next;

  logic mul_go;

  assign mul_go = !((op == pctf_pkg::OP_DERIV) && status.div_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pctf_pkg::S_IDLE;
      op    <= pctf_pkg::OP_ERR_DT;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      pctf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = pctf_pkg::S_DECIDE;
        end
      end
      pctf_pkg::S_DECIDE: begin
        if (status.is_clear) begin
          state_next = pctf_pkg::S_CLEAR;
        end else if (!status.dt_pos) begin
          state_next = pctf_pkg::S_HOLD;
        end else begin
          state_next = pctf_pkg::S_MSTART;
          op_next    = pctf_pkg::OP_ERR_DT;
        end
      end
      pctf_pkg::S_MSTART: begin
        if (mul_go) begin
          state_next = pctf_pkg::S_MWAIT;
        end
      end
      pctf_pkg::S_MWAIT: begin
        if (status.mul_done) begin
          unique case (op)
            pctf_pkg::OP_ERR_DT: state_next = pctf_pkg::S_INTEG;
            pctf_pkg::OP_PROP: begin
              op_next    = pctf_pkg::OP_INTEG;
              state_next = pctf_pkg::S_MSTART;
            end
            pctf_pkg::OP_INTEG: begin
              op_next    = pctf_pkg::OP_DERIV;
              state_next = pctf_pkg::S_MSTART;
            end
            pctf_pkg::OP_DERIV: state_next = pctf_pkg::S_COMMIT;
          endcase
        end
      end
      pctf_pkg::S_INTEG: begin
        op_next    = pctf_pkg::OP_PROP;
        state_next = pctf_pkg::S_MSTART;
      end
      pctf_pkg::S_COMMIT, pctf_pkg::S_CLEAR, pctf_pkg::S_HOLD: begin
        if (status.out_free) begin
          state_next = pctf_pkg::S_IDLE;
        end
      end
      default: state_next = pctf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = op;
    in_ready = 1'b0;
    unique case (state)
      pctf_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      pctf_pkg::S_DECIDE: begin
        cmd.div_start = !status.is_clear && status.dt_pos;
      end
      pctf_pkg::S_MSTART: begin
        cmd.mul_start = mul_go;
      end
      pctf_pkg::S_MWAIT: begin
        if (status.mul_done) begin
          if (op == pctf_pkg::OP_ERR_DT) begin
            cmd.edt_en = 1'b1;
          end else begin
            cmd.acc_en = 1'b1;
          end
        end
      end
      pctf_pkg::S_INTEG:  cmd.integ_en  = 1'b1;
      pctf_pkg::S_COMMIT: cmd.commit_en = status.out_free;
      pctf_pkg::S_CLEAR:  cmd.clear_en  = status.out_free;
      pctf_pkg::S_HOLD:   cmd.hold_en   = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/pid_controller_two_form_core.sv -----
// pid_controller_two_form_core: top level of the positional/incremental pid controller
// joins the sequencer and the datapath to the stream and config ports
// depends on pctf_pkg, pctf_ctrl, pctf_dp
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   measurement, timestamp; tuser cmd
//   m_*       out        m_tvalid/m_tready   drive; tuser updated
//   wr_*      in         wr_en               wr_index, wr_data
//
// an update makes four passes of the shared one-bit-per-cycle multiplier (error times dt,
// proportional, integral, derivative); the result is registered in the commit state, which
// waits for the output register to be free and then returns to idle, where the next
// transaction can be taken; the divider runs alongside; a clear or a held result skips the multiplier
// rst is synchronous and clears the loop state and loads the register reset values
// a result waits in the output register while the next transaction is taken in
module pid_controller_two_form_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // measurement [DATA_WIDTH-1:0], timestamp [DATA_WIDTH+31:DATA_WIDTH], zero pad
  input  logic [((DATA_WIDTH+39)/8)*8-1:0]  s_tdata,
  // cmd
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // drive [DATA_WIDTH-1:0], zero pad
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
  // updated
  output logic                              m_tuser,
  input  logic                              wr_en,
  input  logic [pctf_pkg::REG_INDEX_W-1:0]  wr_index,
  input  logic [DATA_WIDTH-1:0]             wr_data
);

  localparam int OW = ((DATA_WIDTH + 7) / 8) * 8;

  pctf_pkg::dp_cmd_t    cmd;
  pctf_pkg::dp_status_t status;
  logic [DATA_WIDTH-1:0] drive;

  assign m_tdata = OW'(drive);

  pctf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pctf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_cmd         (s_tuser),
    .in_measurement (s_tdata[DATA_WIDTH-1:0]),
    .in_timestamp   (s_tdata[DATA_WIDTH+31:DATA_WIDTH]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_drive      (drive),
    .out_updated    (m_tuser)
  );

endmodule
